>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/brq_pkg.sv
package brq_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_BURST,
        KIND_SINGLE
    } cmd_kind_t;

endpackage

>>> rtl/brq_front.sv
module brq_front #(
    parameter int  DEPTH     = 256,
    parameter int  MAX_BURST = 16,
    parameter type cmd_t     = logic
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [brq_pkg::OP_W-1:0]     s_op,
    input  logic [brq_pkg::DATA_W-1:0]   s_data_in,
    input  logic [brq_pkg::COUNT_W-1:0]  s_count,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output cmd_t                         cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int MW = $clog2(MAX_BURST + 1);
    localparam int SW = ((PW > MW) ? PW : MW) + 1;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] fill_left;
    logic [MW-1:0] n_sat, n_eff;
    logic          short_req;
    logic          accept;

    function automatic logic [PW-1:0] ptr_add(logic [PW-1:0] p, logic [MW-1:0] n);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(n);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return PW'(s);
    endfunction

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;
    assign accept    = s_tvalid && cmd_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;

        n_sat = (32'(s_count) > MAX_BURST) ? MW'(MAX_BURST) : MW'(s_count);
        if (32'(n_sat) > 32'(fill_reg)) begin
            n_eff     = MW'(fill_reg);
            short_req = 1'b1;
        end else begin
            n_eff     = n_sat;
            short_req = 1'b0;
        end
        fill_left = fill_reg - LW'(n_eff);

        cmd        = '0;
        cmd.kind   = brq_pkg::KIND_SINGLE;
        cmd.addr   = head_reg;
        cmd.wdata  = s_data_in;
        cmd.status = brq_pkg::ST_OK;
        cmd.level  = fill_reg;

        case (s_op)
            brq_pkg::OP_APPEND: begin
                cmd.kind  = brq_pkg::KIND_WRITE;
                cmd.addr  = tail_reg;
                cmd.n     = MW'(1);
                tail_next = ptr_add(tail_reg, MW'(1));
                if (fill_reg == LW'(DEPTH)) begin
                    head_next  = ptr_add(head_reg, MW'(1));
                    cmd.status = brq_pkg::ST_FULL;
                end else begin
                    fill_next = fill_reg + LW'(1);
                    cmd.level = fill_reg + LW'(1);
                end
            end
            brq_pkg::OP_CLEAR: begin
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
                cmd.level = '0;
            end
            brq_pkg::OP_POP, brq_pkg::OP_PEEK, brq_pkg::OP_REMOVE: begin
                cmd.n      = n_eff;
                cmd.status = short_req ? brq_pkg::ST_SHORT : brq_pkg::ST_OK;
                if (s_op != brq_pkg::OP_PEEK) begin
                    head_next = ptr_add(head_reg, n_eff);
                    fill_next = fill_left;
                    cmd.level = fill_left;
                end
                if (s_op != brq_pkg::OP_REMOVE && n_eff != '0) begin
                    cmd.kind = brq_pkg::KIND_BURST;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else if (accept) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> rtl/brq_cmd_queue.sv
module brq_cmd_queue #(
    parameter type cmd_t = logic
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int QD  = brq_pkg::CMDQ_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    cmd_t           slot_reg [QD];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] cnt_reg;
    logic           do_push, do_pop;

    assign push_ready = (cnt_reg != QCW'(QD));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + QAW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + QAW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QCW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/brq_back.sv
`include "assert_macros.svh"

module brq_back #(
    parameter int  DEPTH     = 256,
    parameter int  MAX_BURST = 16,
    parameter type cmd_t     = logic
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  cmd_t                                cmd,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [brq_pkg::DATA_W-1:0]          m_data_out,
    output logic [brq_pkg::STATUS_W-1:0]        m_status,
    output logic [$clog2(MAX_BURST + 1)-1:0]    m_moved,
    output logic [$clog2(DEPTH + 1)-1:0]        m_level,
    output logic                                m_tlast
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int MW = $clog2(MAX_BURST + 1);

    logic [brq_pkg::DATA_W-1:0]   mem [DEPTH];
    logic [brq_pkg::DATA_W-1:0]   rd_data_reg;
    logic [PW-1:0]                addr_reg;
    logic [PW-1:0]                addr_cur;
    logic [MW-1:0]                idx_reg;
    logic                         m_valid_reg;
    logic                         burst_reg;
    logic                         last_reg;
    logic [brq_pkg::STATUS_W-1:0] status_reg;
    logic [MW-1:0]                moved_reg;
    logic [LW-1:0]                level_reg;
    logic                         adv;
    logic                         last_now;
    logic                         is_burst;

    assign adv       = !m_valid_reg || m_tready;
    assign is_burst  = (cmd.kind == brq_pkg::KIND_BURST);
    assign addr_cur  = (idx_reg == '0) ? cmd.addr : addr_reg;
    assign last_now  = !is_burst || (32'(idx_reg) + 1 == 32'(cmd.n));
    assign cmd_ready = adv && last_now;

    assign m_tvalid   = m_valid_reg;
    assign m_data_out = burst_reg ? rd_data_reg : '0;
    assign m_status   = status_reg;
    assign m_moved    = moved_reg;
    assign m_level    = level_reg;
    assign m_tlast    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (adv) begin
            m_valid_reg <= cmd_valid;
            if (cmd_valid) begin
                burst_reg  <= is_burst;
                last_reg   <= last_now;
                status_reg <= cmd.status;
                moved_reg  <= cmd.n;
                level_reg  <= cmd.level;
                if (last_now) begin
                    idx_reg <= '0;
                end else begin
                    idx_reg  <= idx_reg + MW'(1);
                    addr_reg <= (addr_cur == PW'(DEPTH - 1)) ? '0 : addr_cur + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && cmd_valid && cmd.kind == brq_pkg::KIND_WRITE) begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (adv && cmd_valid && is_burst) begin
            rd_data_reg <= mem[addr_cur];
        end
    end

    `ASSERT_NEXT(a_burst_holds_cmd, aclk, aresetn, adv && cmd_valid && !last_now, cmd_valid && is_burst, "burst command left the queue early")
    `ASSERT_NEXT(a_last_resets_idx, aclk, aresetn, adv && cmd_valid && last_now, idx_reg == '0, "burst index not cleared after last item")
    `ASSERT_IMPLY(a_multi_only_burst, aclk, aresetn, m_valid_reg && !m_tlast, burst_reg, "non-final item from a single-result command")

endmodule

>>> rtl/byte_ring_queue.sv
// Circular byte queue with overwrite-oldest append, driven by one operation per
// input item (append, pop, peek, remove, clear). The front end accepts one item
// per cycle while its four-entry command queue has room; append, remove, clear and
// unknown codes give one result, pop and peek give n results (n = clipped count,
// one result when n is zero), one byte per cycle while the output is not stalled,
// from the single read port of the byte store. The first result of an item passes
// through the command queue and then the output register. The byte store has no
// reset; only the pointers, counters and valid flags are cleared, so the block is
// usable straight out of reset.
module byte_ring_queue #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op[2:0], data_in[10:3], count[15:11]
    input  logic [15:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // data_out, status, moved, level (from bit 0 up), zero padded to bytes
    output logic [((10 + $clog2(MAX_BURST + 1) + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                            m_tdata,
    output logic                            m_tlast
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int MW  = $clog2(MAX_BURST + 1);
    localparam int UW  = brq_pkg::DATA_W + brq_pkg::STATUS_W + MW + LW;
    localparam int TDW = ((UW + 7) / 8) * 8;

    typedef struct packed {
        brq_pkg::cmd_kind_t           kind;
        logic [PW-1:0]                addr;
        logic [brq_pkg::DATA_W-1:0]   wdata;
        logic [MW-1:0]                n;
        logic [brq_pkg::STATUS_W-1:0] status;
        logic [LW-1:0]                level;
    } cmd_t;

    cmd_t                         f_cmd, b_cmd;
    logic                         f_valid, f_ready;
    logic                         b_valid, b_ready;
    logic [brq_pkg::DATA_W-1:0]   data_out;
    logic [brq_pkg::STATUS_W-1:0] status;
    logic [MW-1:0]                moved;
    logic [LW-1:0]                level;

    brq_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .cmd_t     (cmd_t)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tdata[2:0]),
        .s_data_in (s_tdata[10:3]),
        .s_count   (s_tdata[15:11]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    brq_cmd_queue #(
        .cmd_t (cmd_t)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_cmd)
    );

    brq_back #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .cmd_t     (cmd_t)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd        (b_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_data_out (data_out),
        .m_status   (status),
        .m_moved    (moved),
        .m_level    (level),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = TDW'({level, moved, status, data_out});

endmodule
